### sv/rgbhsl_pkg.sv
// types, constants and the divider step for the rgb to hsl converter
package rgbhsl_pkg;

   localparam int COMP_W = 8;
   localparam int QUO_W = 15;
   localparam int NUM_W = COMP_W + QUO_W;
   localparam int SUM_W = COMP_W + 1;
   localparam int DIV_STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS_PER_STAGE;

   localparam int LIGHT_P_W = 21;
   localparam int LIGHT_RECIP_SHIFT = 26;
   localparam int LIGHT_PROD_W = 2 * LIGHT_P_W;
   localparam logic [LIGHT_P_W-1:0] LIGHT_RECIP = 21'd1315861;

   localparam logic [QUO_W-1:0] HUE_GREEN_BASE = 15'd7680;
   localparam logic [QUO_W-1:0] HUE_BLUE_BASE = 15'd15360;
   localparam logic [QUO_W-1:0] HUE_FULL_TURN = 15'd23040;
   localparam logic [QUO_W-1:0] PCT_FULL = 15'd25600;
   localparam logic [SUM_W-1:0] COMP_MAX = 9'd255;
   localparam logic [SUM_W-1:0] TWICE_COMP_MAX = 9'd510;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [COMP_W-1:0] rem;
      logic [QUO_W-1:0]  num;
      logic [QUO_W-1:0]  quo;
      logic [COMP_W-1:0] den;
   } div_lane_type;

   typedef struct packed {
      logic              valid;
      sector_type        sector;
      logic              neg;
      logic [COMP_W-1:0] diff;
      logic [COMP_W-1:0] range;
      logic [SUM_W-1:0]  sum;
      logic [COMP_W-1:0] den;
   } front_type;

   typedef struct packed {
      logic             valid;
      logic             grey;
      sector_type       sector;
      logic             neg;
      logic [QUO_W-1:0] light;
      div_lane_type     hue_lane;
      div_lane_type     sat_lane;
   } div_pipe_type;

   typedef struct packed {
      logic             valid;
      logic             grey;
      logic [QUO_W-1:0] hue;
      logic [QUO_W-1:0] sat;
      logic [QUO_W-1:0] light;
   } result_type;

   // restoring division, a few quotient bits per call
   function automatic div_lane_type div_step(div_lane_type lane_in);
      div_lane_type    lane;
      logic [COMP_W:0] trial;
      lane = lane_in;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         trial = {lane.rem, lane.num[QUO_W-1]};
         lane.num = {lane.num[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, lane.den}) begin
            trial = trial - {1'b0, lane.den};
            lane.quo = {lane.quo[QUO_W-2:0], 1'b1};
         end else begin
            lane.quo = {lane.quo[QUO_W-2:0], 1'b0};
         end
         lane.rem = trial[COMP_W-1:0];
      end
      return lane;
   endfunction

endpackage

### sv/rgb_to_hsl_converter_top.sv
// rgb to hsl converter: pipelined top level
//
// req channel: one sRGB pixel per transfer, red, green and blue in req_tdata.
// rsp channel: hue (degrees x 64), saturation and lightness (percent x 256)
// in rsp_tdata, grey flag in rsp_tuser. one result per pixel, in order.
// the req transfer reaches rsp_tvalid through one front stage, one numerator
// and lightness multiply stage, five divider stages (three quotient bits each,
// hue and saturation dividers side by side) and the output register.
// throughput: one pixel per cycle while the receiver keeps rsp_tready high.
// when the receiver stalls the whole pipeline holds and req_tready drops;
// nothing is lost or repeated, and req_tready returns with rsp_tready.
// req_tready is high whenever the output register is empty or being taken.
// reset (synchronous, active high) clears all valid bits; no pixel survives
// it and req_tready is high in the first cycle after it.
// grey pixels (max equals min) give hue 0 and saturation 0 with grey set.
module rgb_to_hsl_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // hue [14:0], saturation [29:15], lightness [44:30]
   output logic [0:0]  rsp_tuser   // grey [0]
);

   logic advance;

   logic [rgbhsl_pkg::COMP_W-1:0] red;
   logic [rgbhsl_pkg::COMP_W-1:0] green;
   logic [rgbhsl_pkg::COMP_W-1:0] blue;
   logic [rgbhsl_pkg::COMP_W-1:0] hi;
   logic [rgbhsl_pkg::COMP_W-1:0] lo;
   logic [rgbhsl_pkg::SUM_W-1:0]  sum;
   logic [rgbhsl_pkg::SUM_W-1:0]  other_den;

   rgbhsl_pkg::front_type    front_ff;
   rgbhsl_pkg::front_type    front_in;
   rgbhsl_pkg::div_pipe_type div_ff [0:rgbhsl_pkg::DIV_STAGES];
   rgbhsl_pkg::div_pipe_type div_in [0:rgbhsl_pkg::DIV_STAGES];
   rgbhsl_pkg::result_type   out_ff;
   rgbhsl_pkg::result_type   out_in;

   logic [rgbhsl_pkg::NUM_W-1:0]        hue_num;
   logic [rgbhsl_pkg::NUM_W-1:0]        sat_num;
   logic [rgbhsl_pkg::LIGHT_P_W-1:0]    light_p;
   logic [rgbhsl_pkg::LIGHT_PROD_W-1:0] light_prod;

   logic [rgbhsl_pkg::QUO_W-1:0] hue_base;
   logic [rgbhsl_pkg::QUO_W-1:0] hue_q;
   logic [rgbhsl_pkg::QUO_W-1:0] hue_frac;

   assign advance    = !out_ff.valid || rsp_tready;
   assign req_tready = advance;

   // front stage: extremes, sector, distance and saturation divisor
   always_comb begin
      red   = req_tdata[7:0];
      green = req_tdata[15:8];
      blue  = req_tdata[23:16];
      hi = (red >= green) ? red : green;
      hi = (hi >= blue) ? hi : blue;
      lo = (red <= green) ? red : green;
      lo = (lo <= blue) ? lo : blue;
      sum = {1'b0, hi} + {1'b0, lo};
      other_den = rgbhsl_pkg::TWICE_COMP_MAX - sum;

      front_in.valid = req_tvalid;
      front_in.range = hi - lo;
      front_in.sum   = sum;
      front_in.den   = (sum < rgbhsl_pkg::COMP_MAX) ? sum[rgbhsl_pkg::COMP_W-1:0]
                                                    : other_den[rgbhsl_pkg::COMP_W-1:0];
      if (hi == red) begin
         front_in.sector = rgbhsl_pkg::SECTOR_RED;
         front_in.neg    = green < blue;
         front_in.diff   = (green < blue) ? blue - green : green - blue;
      end else if (hi == green) begin
         front_in.sector = rgbhsl_pkg::SECTOR_GREEN;
         front_in.neg    = blue < red;
         front_in.diff   = (blue < red) ? red - blue : blue - red;
      end else begin
         front_in.sector = rgbhsl_pkg::SECTOR_BLUE;
         front_in.neg    = red < green;
         front_in.diff   = (red < green) ? green - red : red - green;
      end
   end

   // numerators and lightness by reciprocal of 51
   always_comb begin
      hue_num = ({{rgbhsl_pkg::QUO_W{1'b0}}, front_ff.diff} << 12)
              - ({{rgbhsl_pkg::QUO_W{1'b0}}, front_ff.diff} << 8);
      sat_num = ({{rgbhsl_pkg::QUO_W{1'b0}}, front_ff.range} << 14)
              + ({{rgbhsl_pkg::QUO_W{1'b0}}, front_ff.range} << 13)
              + ({{rgbhsl_pkg::QUO_W{1'b0}}, front_ff.range} << 10);
      light_p = ({{(rgbhsl_pkg::LIGHT_P_W-rgbhsl_pkg::SUM_W){1'b0}}, front_ff.sum} << 11)
              + ({{(rgbhsl_pkg::LIGHT_P_W-rgbhsl_pkg::SUM_W){1'b0}}, front_ff.sum} << 9);
      light_prod = {{rgbhsl_pkg::LIGHT_P_W{1'b0}}, light_p}
                 * {{rgbhsl_pkg::LIGHT_P_W{1'b0}}, rgbhsl_pkg::LIGHT_RECIP};

      div_in[0].valid  = front_ff.valid;
      div_in[0].grey   = front_ff.range == '0;
      div_in[0].sector = front_ff.sector;
      div_in[0].neg    = front_ff.neg;
      div_in[0].light  = light_prod[rgbhsl_pkg::LIGHT_RECIP_SHIFT +: rgbhsl_pkg::QUO_W];
      div_in[0].hue_lane.rem = hue_num[rgbhsl_pkg::NUM_W-1 -: rgbhsl_pkg::COMP_W];
      div_in[0].hue_lane.num = hue_num[rgbhsl_pkg::QUO_W-1:0];
      div_in[0].hue_lane.quo = '0;
      div_in[0].hue_lane.den = front_ff.range;
      div_in[0].sat_lane.rem = sat_num[rgbhsl_pkg::NUM_W-1 -: rgbhsl_pkg::COMP_W];
      div_in[0].sat_lane.num = sat_num[rgbhsl_pkg::QUO_W-1:0];
      div_in[0].sat_lane.quo = '0;
      div_in[0].sat_lane.den = front_ff.den;
   end

   // divider stages
   for (genvar s = 1; s <= rgbhsl_pkg::DIV_STAGES; s++) begin : g_div
      always_comb begin
         div_in[s] = div_ff[s-1];
         div_in[s].hue_lane = rgbhsl_pkg::div_step(div_ff[s-1].hue_lane);
         div_in[s].sat_lane = rgbhsl_pkg::div_step(div_ff[s-1].sat_lane);
      end
   end

   // hue assembly: falling sectors use the ceiling of the quotient
   always_comb begin
      hue_q    = div_ff[rgbhsl_pkg::DIV_STAGES].hue_lane.quo;
      hue_frac = hue_q + {{(rgbhsl_pkg::QUO_W-1){1'b0}},
                          |div_ff[rgbhsl_pkg::DIV_STAGES].hue_lane.rem};
      case (div_ff[rgbhsl_pkg::DIV_STAGES].sector)
         rgbhsl_pkg::SECTOR_RED:
            hue_base = div_ff[rgbhsl_pkg::DIV_STAGES].neg ? rgbhsl_pkg::HUE_FULL_TURN : '0;
         rgbhsl_pkg::SECTOR_GREEN: hue_base = rgbhsl_pkg::HUE_GREEN_BASE;
         rgbhsl_pkg::SECTOR_BLUE:  hue_base = rgbhsl_pkg::HUE_BLUE_BASE;
         default:                  hue_base = '0;
      endcase

      out_in.valid = div_ff[rgbhsl_pkg::DIV_STAGES].valid;
      out_in.grey  = div_ff[rgbhsl_pkg::DIV_STAGES].grey;
      out_in.light = div_ff[rgbhsl_pkg::DIV_STAGES].light;
      if (div_ff[rgbhsl_pkg::DIV_STAGES].grey) begin
         out_in.hue = '0;
         out_in.sat = '0;
      end else begin
         out_in.hue = div_ff[rgbhsl_pkg::DIV_STAGES].neg ? hue_base - hue_frac
                                                         : hue_base + hue_q;
         out_in.sat = div_ff[rgbhsl_pkg::DIV_STAGES].sat_lane.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
         out_ff.valid   <= 1'b0;
         for (int s = 0; s <= rgbhsl_pkg::DIV_STAGES; s++) begin
            div_ff[s].valid <= 1'b0;
         end
      end else if (advance) begin
         front_ff <= front_in;
         out_ff   <= out_in;
         for (int s = 0; s <= rgbhsl_pkg::DIV_STAGES; s++) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {3'b000, out_ff.light, out_ff.sat, out_ff.hue};
   assign rsp_tuser  = out_ff.grey;

   // grey results carry zero hue and saturation
   assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && out_ff.grey |-> out_ff.hue == '0 && out_ff.sat == '0)
      else $error("grey result with nonzero hue or saturation");

   // coloured results stay inside their ranges
   assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && !out_ff.grey |-> out_ff.hue < rgbhsl_pkg::HUE_FULL_TURN
         && out_ff.sat != '0 && out_ff.sat <= rgbhsl_pkg::PCT_FULL)
      else $error("hue or saturation out of range");

   assert property (@(posedge clock) disable iff (reset)
      out_ff.valid |-> out_ff.light <= rgbhsl_pkg::PCT_FULL)
      else $error("lightness out of range");

   // nothing leaves the pipeline right after reset
   assert property (@(posedge clock) reset |=> !out_ff.valid && !front_ff.valid)
      else $error("valid bits survive reset");

endmodule

### tb/rgb_to_hsl_converter_top_test.sv
// self-checking testbench for the rgb to hsl converter top level
module rgb_to_hsl_converter_top_test;

   localparam int COMP_W = rgbhsl_pkg::COMP_W;
   localparam int QUO_W = rgbhsl_pkg::QUO_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RESET_CYCLES = 12;
   localparam int PIPE_LATENCY = 8;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [QUO_W-1:0] hue;
      logic [QUO_W-1:0] saturation;
      logic [QUO_W-1:0] lightness;
      logic             grey;
   } hsl_result_type;

   // pixels as {red, green, blue}
   localparam logic [23:0] EDGE_PIXELS [24] = '{
      24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
      24'h00ffff, 24'hff00ff, 24'h808080, 24'h010000, 24'h000100, 24'h000001,
      24'hff0001, 24'hfffeff, 24'hfeffff, 24'h7f7f00, 24'hc83636, 24'hc83737,
      24'hff0080, 24'h010203, 24'h6432c8, 24'hfefeff, 24'hfffffe, 24'h01ff00
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   hsl_result_type hsl_expected_q [$];
   int             error_count;
   int             pixels_sent;
   int             results_checked;
   int             grey_results;
   int             cycle_count;
   int             rsp_hold_request;
   int             long_holds_done;
   bit             no_idle;

   rgb_to_hsl_converter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // red [7:0], green [15:8], blue [23:16]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // hue [14:0], saturation [29:15], lightness [44:30]
      .rsp_tuser  (rsp_tuser)    // grey [0]
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic hsl_result_type rgb_to_hsl(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                                 logic [COMP_W-1:0] b);
      hsl_result_type         res;
      int                     ri;
      int                     gi;
      int                     bi;
      int                     hi;
      int                     lo;
      int                     span;
      int                     total;
      int                     num;
      int                     hue_val;
      rgbhsl_pkg::sector_type sector;
      ri = r;
      gi = g;
      bi = b;
      hi = (ri > gi) ? ri : gi;
      hi = (hi > bi) ? hi : bi;
      lo = (ri < gi) ? ri : gi;
      lo = (lo < bi) ? lo : bi;
      span = hi - lo;
      total = hi + lo;
      res = '0;
      res.lightness = QUO_W'((total * 12800) / 255);
      res.grey = (span == 0);
      if (span != 0) begin
         if (hi == ri) sector = rgbhsl_pkg::SECTOR_RED;
         else if (hi == gi) sector = rgbhsl_pkg::SECTOR_GREEN;
         else sector = rgbhsl_pkg::SECTOR_BLUE;
         case (sector)
            rgbhsl_pkg::SECTOR_RED: begin
               num = 3840 * (gi - bi);
               if (gi < bi) num += 23040 * span;
            end
            rgbhsl_pkg::SECTOR_GREEN: num = 3840 * (bi - ri) + 7680 * span;
            default: num = 3840 * (ri - gi) + 15360 * span;
         endcase
         if (num < 0) num = 0;
         hue_val = num / span;
         if (hue_val >= 23040) hue_val -= 23040;
         res.hue = QUO_W'(hue_val);
         if (total < 255) res.saturation = QUO_W'((span * 25600) / total);
         else res.saturation = QUO_W'((span * 25600) / (510 - total));
      end
      return res;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {b, g, r};
      do @(posedge clock); while (!req_tready);
      hsl_expected_q.push_back(rgb_to_hsl(r, g, b));
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                               output logic [7:0] b);
      int kind;
      kind = $urandom_range(0, 9);
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case (kind)
         0: begin
            g = r;
            b = r;
         end
         1: g = r;
         2: b = g;
         3: b = r;
         4: begin
            r = 8'($urandom_range(118, 137));
            g = 8'($urandom_range(118, 137));
            b = 8'($urandom_range(118, 137));
         end
         5: begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
         end
         default: ;
      endcase
   endtask

   task automatic wait_for_drain();
      req_tvalid = 1'b0;
      while (hsl_expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic report_field(string field, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
                  actual);
         error_count++;
      end
   endtask

   task automatic test_edge_pixels();
      for (int i = 0; i < 24; i++)
         send_pixel(EDGE_PIXELS[i][23:16], EDGE_PIXELS[i][15:8], EDGE_PIXELS[i][7:0]);
      wait_for_drain();
   endtask

   task automatic test_random_pixels(int count);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         random_pixel(r, g, b);
         send_pixel(r, g, b);
      end
   endtask

   task automatic test_back_to_back(int count);
      no_idle = 1'b1;
      test_random_pixels(count);
      wait_for_drain();
      no_idle = 1'b0;
   endtask

   // receiver holds off while pixels keep coming, so the input stalls
   task automatic test_output_stall(int count);
      rsp_hold_request = LONG_HOLD;
      no_idle = 1'b1;
      test_random_pixels(count);
      wait_for_drain();
      no_idle = 1'b0;
   endtask

   initial begin
      hsl_result_type expected;
      hsl_result_type actual;
      int             stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
            long_holds_done++;
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         actual.hue = rsp_tdata[14:0];
         actual.saturation = rsp_tdata[29:15];
         actual.lightness = rsp_tdata[44:30];
         actual.grey = rsp_tuser[0];
         if (hsl_expected_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual hue %0d", $time,
                     actual.hue);
            error_count++;
         end else begin
            expected = hsl_expected_q.pop_front();
            report_field("hue", expected.hue, actual.hue);
            report_field("saturation", expected.saturation, actual.saturation);
            report_field("lightness", expected.lightness, actual.lightness);
            report_field("grey", expected.grey, actual.grey);
            results_checked++;
            if (expected.grey) grey_results++;
         end
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rgb_to_hsl_converter_top_test: done, errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      pixels_sent = 0;
      results_checked = 0;
      grey_results = 0;
      rsp_hold_request = 0;
      long_holds_done = 0;
      no_idle = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_pixels();
      test_random_pixels(700);
      wait_for_drain();
      test_output_stall(60);
      test_back_to_back(200);
      test_random_pixels(600);
      wait_for_drain();
      repeat (PIPE_LATENCY * 4) @(negedge clock);

      $display("covered %0d pixels and %0d checked results (%0d grey), including edge",
               pixels_sent, results_checked, grey_results);
      $display("values, ties, %0d long output stall(s) and a back-to-back stretch",
               long_holds_done);
      if (error_count == 0) begin
         $display("rgb_to_hsl_converter_top_test: done, clean");
      end else begin
         $display("rgb_to_hsl_converter_top_test: done, errors");
      end
      $finish;
   end

endmodule
